// ===== design/tea_block_cipher_top_macros.svh =====
// assertion macros used by the checker file
`ifndef TEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define TEA_BLOCK_CIPHER_TOP_MACROS_SVH

// condition implies consequence at the same edge
`define TEA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence at the next edge
`define TEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tea_pkg.sv =====
package tea_pkg;

    localparam int MAX_ROUNDS = 64;
    localparam int RND_W      = $clog2(MAX_ROUNDS + 1);
    localparam int N_HALF     = 2 * MAX_ROUNDS;
    localparam int WORD_W     = 32;
    localparam int RC_W       = 7;
    localparam int CFG_ADDR_W = 3;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_ROUNDS = 3'd4
    } tea_reg_t;

    // key words and the clamped round count, as the datapath sees them
    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
        logic [RND_W-1:0]  rounds;
    } tea_cfg_t;

    typedef struct packed {
        logic              dec;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] sum;
    } tea_stage_t;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] kl,
        input logic [WORD_W-1:0] kr
    );
        return ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
    endfunction

endpackage

// ===== design/tea_block_cipher_top.sv =====
// TEA block cipher, fully pipelined: one 64-bit block is taken every clock while s_tready
// is high. Its result reaches m_tvalid through an entry stage loaded at the accepting edge,
// one stage per half round for 64 rounds and one output register. Every block walks the full
// 128 half-round stages; stages past the programmed round count pass the block through
// unchanged, so latency does not depend on the round count. A round count above 64 acts as
// 64, zero returns the block unchanged.
// Key and round count are loaded through the write port; the user must do so only while no
// block is in flight, as the block does not enforce it. When the result side stalls, a
// two-entry output buffer takes the last block in the pipe and the pipe then holds; s_tready
// drops as soon as the second entry is filled and rises again once that entry moves on.
module tea_block_cipher_top
    import tea_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // block_y, block_z
    input  logic [0:0]            s_tuser,   // func (0 encrypt, 1 decrypt)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata    // out_y, out_z
);

    logic [WORD_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [RC_W-1:0]   rounds_reg;
    tea_cfg_t          cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            rounds_reg <= RC_W'(32);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_KEY0:   key0_reg   <= cfg_wdata;
                REG_KEY1:   key1_reg   <= cfg_wdata;
                REG_KEY2:   key2_reg   <= cfg_wdata;
                REG_KEY3:   key3_reg   <= cfg_wdata;
                REG_ROUNDS: rounds_reg <= cfg_wdata[RC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.k0 = key0_reg;
        cfg.k1 = key1_reg;
        cfg.k2 = key2_reg;
        cfg.k3 = key3_reg;
        cfg.rounds = (32'(rounds_reg) > 32'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS)
                                                           : RND_W'(rounds_reg);
    end

    logic              en;
    logic              pipe_valid;
    logic [WORD_W-1:0] pipe_y, pipe_z;
    logic              pipe_take;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [63:0] skid_data_reg, skid_data_next;

    // pipe moves whenever the skid entry is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    tea_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_dec    (s_tuser[0]),
        .in_y      (s_tdata[31:0]),
        .in_z      (s_tdata[63:32]),
        .out_valid (pipe_valid),
        .out_y     (pipe_y),
        .out_z     (pipe_z)
    );

    assign pipe_take = en && pipe_valid;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = pipe_take;
                m_data_next  = {pipe_z, pipe_y};
            end
        end else if (pipe_take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = {pipe_z, pipe_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/tea_pipe.sv =====
module tea_pipe
    import tea_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tea_cfg_t          cfg,
    input  logic              in_valid,
    input  logic              in_dec,
    input  logic [WORD_W-1:0] in_y,
    input  logic [WORD_W-1:0] in_z,
    output logic              out_valid,
    output logic [WORD_W-1:0] out_y,
    output logic [WORD_W-1:0] out_z
);

    tea_stage_t        st_reg  [0:N_HALF];
    tea_stage_t        st_next [0:N_HALF];
    logic [N_HALF:0]   vld_reg;

    // entry stage: decrypt starts the sum at delta times rounds
    assign st_next[0] = {in_dec, in_y, in_z,
                         in_dec ? WORD_W'(DELTA * WORD_W'(cfg.rounds)) : DELTA};

    // one half round per stage: even stages update the first word of the round,
    // odd stages the second word and step the sum
    for (genvar k = 0; k < N_HALF; k++) begin : g_half
        localparam logic [RND_W-1:0] RND = RND_W'(k / 2);
        localparam bit               ODD = (k % 2) == 1;

        tea_stage_t        cur;
        tea_stage_t        nxt;
        logic              active;
        logic              upd_y;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] kl;
        logic [WORD_W-1:0] kr;
        logic [WORD_W-1:0] m;

        assign cur    = st_reg[k];
        assign active = cfg.rounds > RND;
        assign upd_y  = ODD ? cur.dec : !cur.dec;

        always_comb begin
            nxt = cur;
            v   = upd_y ? cur.z  : cur.y;
            kl  = upd_y ? cfg.k0 : cfg.k2;
            kr  = upd_y ? cfg.k1 : cfg.k3;
            m   = tea_mix(v, cur.sum, kl, kr);
            if (active) begin
                if (upd_y) begin
                    nxt.y = cur.dec ? cur.y - m : cur.y + m;
                end else begin
                    nxt.z = cur.dec ? cur.z - m : cur.z + m;
                end
                if (ODD) begin
                    nxt.sum = cur.dec ? cur.sum - DELTA : cur.sum + DELTA;
                end
            end
        end

        assign st_next[k+1] = nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N_HALF-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= N_HALF; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = vld_reg[N_HALF];
    assign out_y     = st_reg[N_HALF].y;
    assign out_z     = st_reg[N_HALF].z;

endmodule

// ===== design/tea_chk.sv =====
`include "tea_block_cipher_top_macros.svh"

module tea_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result beat stays offered and unchanged
    `TEA_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `TEA_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed while stalled")

    // input only blocks while a result is waiting
    `TEA_ASSERT_NOW(a_full_has_out, aclk, aresetn, !s_tready, m_tvalid, "s_tready low with no result offered")

    // reset empties the block
    `TEA_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid && s_tready, "block not empty after reset")

endmodule

bind tea_block_cipher_top tea_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
